// ----- sv/ffsx_pkg.sv -----
// Shared types and constants for the fixed frame sync XOR checker.
`default_nettype none
package ffsx_pkg;

    // Fixed record and field layout
    localparam int RECORD_BYTES = 8;
    localparam int REC_W        = 8 * RECORD_BYTES;
    localparam int REC_START    = 6;
    localparam int SEQ_POS      = 4;
    localparam int LEN_HI_POS   = 2;
    localparam int LEN_LO_POS   = 3;
    localparam int IDX_W        = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_LEN = 2'd2;

    localparam logic [7:0]  HEADER_RST  = 8'hAA;
    localparam logic [7:0]  FOOTER_RST  = 8'h55;
    localparam logic [15:0] EXP_LEN_RST = 16'd96;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_MOTOR    = 2'd0,
        KIND_FOOTER   = 2'd1,
        KIND_CHECKSUM = 2'd2,
        KIND_LENGTH   = 2'd3
    } kind_t;

    // Control for one record cell
    typedef struct packed {
        logic load;
        logic shift;
    } rec_ctl_t;

endpackage
`default_nettype wire

// ----- sv/ffsx_byte_if.sv -----
// Input byte channel: valid/ready with one received byte.
`default_nettype none
interface ffsx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- sv/ffsx_result_if.sv -----
// Result channel: valid/ready with one motor record or error result.
`default_nettype none
interface ffsx_result_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [ffsx_pkg::IDX_W-1:0] motor_index;
    logic [ffsx_pkg::REC_W-1:0] record_bits;
    logic [7:0]                 sequence_res;
    logic                       last;

    modport source (output valid, output kind, output motor_index, output record_bits,
                    output sequence_res, output last, input ready);
    modport sink (input valid, input kind, input motor_index, input record_bits,
                  input sequence_res, input last, output ready);
endinterface
`default_nettype wire

// ----- sv/fixed_frame_sync_xor_checker_top.sv -----
// Top level: frame sync, checks and record output of the XOR checksum frame checker.
//
//  channel  | dir | payload                                          | transfer when
//  in_ch    | in  | rx_byte[7:0]                                     | valid && ready
//  out_ch   | out | kind, motor_index, record_bits, sequence_res, last | valid && ready
//  cfg      | in  | cfg_index[1:0], cfg_data[15:0]                   | cfg_we
//
//  One byte per cycle: the window is a chain of FRAME_LEN-1 byte cells plus a sliding XOR.
//  A frame check finishes in the cycle its last byte arrives; results leave from a chain of
//  MOTOR_COUNT record cells, one per cycle while out_ch.ready, first in the cycle after.
//  in_ch stalls only when a byte would complete a frame with the header in place while
//  results of the previous frame are still waiting beyond the one being taken.
//  Reset clears window, fill count and pending results; registers return to defaults.
`default_nettype none
module fixed_frame_sync_xor_checker_top
#(
    parameter int FRAME_LEN   = 112,
    parameter int MOTOR_COUNT = 12
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    ffsx_byte_if.sink                               in_ch,
    ffsx_result_if.source                           out_ch,
    input  wire logic                               cfg_we,
    input  wire logic [ffsx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ffsx_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int HIST   = FRAME_LEN - 1;
    localparam int FILL_W = $clog2(FRAME_LEN);
    localparam int CNT_W  = $clog2(MOTOR_COUNT + 1);
    localparam int REC_W  = ffsx_pkg::REC_W;

    // Configuration registers
    logic [7:0]  header_reg;
    logic [7:0]  footer_reg;
    logic [15:0] exp_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= ffsx_pkg::HEADER_RST;
            footer_reg  <= ffsx_pkg::FOOTER_RST;
            exp_len_reg <= ffsx_pkg::EXP_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ffsx_pkg::REG_HEADER:  header_reg  <= cfg_data[7:0];
                ffsx_pkg::REG_FOOTER:  footer_reg  <= cfg_data[7:0];
                ffsx_pkg::REG_EXP_LEN: exp_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake and window control
    logic in_fire;
    logic out_fire;
    logic full_now;
    logic need_emit;
    logic free;
    logic emit;
    logic good;
    ffsx_pkg::kind_t kind_chk;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        xor_reg, xor_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ffsx_pkg::IDX_W-1:0] idx_reg, idx_next;
    ffsx_pkg::kind_t   kind_reg, kind_next;
    logic [7:0]        seq_reg, seq_next;

    // Window chain: cell 0 is the oldest byte, win_full[HIST] the incoming one
    logic [7:0] win_q [0:HIST-1];
    logic [7:0] win_full [0:FRAME_LEN-1];

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;

    genvar gi;
    generate
        for (gi = 0; gi < HIST; gi++)
        begin : g_win
            logic [7:0] d_in;
            if (gi == HIST - 1)
            begin : g_tail
                assign d_in = in_ch.rx_byte;
            end
            else
            begin : g_mid
                assign d_in = win_q[gi + 1];
            end
            ffsx_byte_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (in_fire),
                .d        (d_in),
                .q        (win_q[gi])
            );
            assign win_full[gi] = win_q[gi];
        end
    endgenerate
    assign win_full[HIST] = in_ch.rx_byte;

    // Decide whether this byte completes a frame that has to be checked
    assign full_now  = (fill_reg == FILL_W'(HIST));
    assign need_emit = full_now && (win_q[0] == header_reg);
    assign free      = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ch.ready);
    assign in_ch.ready = !need_emit || free;
    assign emit      = in_fire && need_emit;

    // Check footer, then checksum, then length
    always_comb
    begin
        if (in_ch.rx_byte != footer_reg)
        begin
            kind_chk = ffsx_pkg::KIND_FOOTER;
        end
        else if (xor_reg != 8'd0)
        begin
            kind_chk = ffsx_pkg::KIND_CHECKSUM;
        end
        else if ({win_q[ffsx_pkg::LEN_HI_POS], win_q[ffsx_pkg::LEN_LO_POS]} != exp_len_reg)
        begin
            kind_chk = ffsx_pkg::KIND_LENGTH;
        end
        else
        begin
            kind_chk = ffsx_pkg::KIND_MOTOR;
        end
    end

    assign good = emit && (kind_chk == ffsx_pkg::KIND_MOTOR);

    // Next values of fill count, sliding XOR and result control
    always_comb
    begin
        fill_next = fill_reg;
        xor_next  = xor_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        kind_next = kind_reg;
        seq_next  = seq_reg;
        if (in_fire)
        begin
            xor_next = xor_reg ^ win_q[0] ^ in_ch.rx_byte;
            if (!full_now)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            else if (good)
            begin
                fill_next = '0;
            end
        end
        if (emit)
        begin
            cnt_next  = good ? CNT_W'(MOTOR_COUNT) : CNT_W'(1);
            idx_next  = '0;
            kind_next = kind_chk;
            seq_next  = good ? win_q[ffsx_pkg::SEQ_POS] : 8'd0;
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            idx_next = idx_reg + ffsx_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            xor_reg  <= '0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
            kind_reg <= ffsx_pkg::KIND_MOTOR;
            seq_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            xor_reg  <= xor_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            kind_reg <= kind_next;
            seq_reg  <= seq_next;
        end
    end

    // Record chain: cell 0 drives the output
    ffsx_pkg::rec_ctl_t rec_ctl;
    logic [REC_W-1:0]   rec_q [0:MOTOR_COUNT-1];

    assign rec_ctl.load  = emit;
    assign rec_ctl.shift = out_fire;

    genvar gm, gj;
    generate
        for (gm = 0; gm < MOTOR_COUNT; gm++)
        begin : g_rec
            logic [REC_W-1:0] rec_bits;
            logic [REC_W-1:0] next_bits;
            for (gj = 0; gj < ffsx_pkg::RECORD_BYTES; gj++)
            begin : g_byte
                localparam int POS = ffsx_pkg::REC_START + gm * ffsx_pkg::RECORD_BYTES + gj;
                localparam int MSB = REC_W - 1 - 8 * gj;
                if (POS < FRAME_LEN)
                begin : g_in
                    assign rec_bits[MSB -: 8] = win_full[POS];
                end
                else
                begin : g_past
                    assign rec_bits[MSB -: 8] = 8'd0;
                end
            end
            if (gm == MOTOR_COUNT - 1)
            begin : g_end
                assign next_bits = '0;
            end
            else
            begin : g_link
                assign next_bits = rec_q[gm + 1];
            end
            ffsx_rec_cell u_rec
            (
                .clk       (clk),
                .ctl       (rec_ctl),
                .load_bits (good ? rec_bits : '0),
                .next_bits (next_bits),
                .q         (rec_q[gm])
            );
        end
    endgenerate

    // Drive the result channel
    assign out_ch.valid        = (cnt_reg != '0);
    assign out_ch.kind         = kind_reg;
    assign out_ch.motor_index  = idx_reg;
    assign out_ch.record_bits  = rec_q[0];
    assign out_ch.sequence_res = seq_reg;
    assign out_ch.last         = (cnt_reg == CNT_W'(1));

    // Checks on the frame and result control
    a_new_results_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> free)
        else $error("frame results loaded over pending results");

    a_good_frame_empties_window: assert property (@(posedge clk) disable iff (!rst_n)
        good |=> (fill_reg == '0))
        else $error("window not emptied after a good frame");

    a_motor_index_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0 && kind_reg == ffsx_pkg::KIND_MOTOR) |->
            ((8'(idx_reg) + 8'(cnt_reg)) == 8'(MOTOR_COUNT)))
        else $error("motor index out of step with pending count");

    a_error_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0 && kind_reg != ffsx_pkg::KIND_MOTOR) |->
            (cnt_reg == CNT_W'(1) && idx_reg == '0 && seq_reg == 8'd0))
        else $error("error result is not a single zeroed result");

endmodule
`default_nettype wire

// ----- sv/ffsx_byte_cell.sv -----
// One byte cell of the receive window shift chain.
`default_nettype none
module ffsx_byte_cell
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift_en,
    input  wire logic [7:0] d,
    output logic      [7:0] q
);

    logic [7:0] q_reg;

    // Take the neighbor's byte on every accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ----- sv/ffsx_rec_cell.sv -----
// One record cell of the output chain: parallel load, shift toward the head.
`default_nettype none
module ffsx_rec_cell
(
    input  wire logic                       clk,
    input  wire ffsx_pkg::rec_ctl_t         ctl,
    input  wire logic [ffsx_pkg::REC_W-1:0] load_bits,
    input  wire logic [ffsx_pkg::REC_W-1:0] next_bits,
    output logic      [ffsx_pkg::REC_W-1:0] q
);

    logic [ffsx_pkg::REC_W-1:0] q_reg;

    // Load a fresh frame, else advance from the neighbor when the head is taken
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            q_reg <= load_bits;
        end
        else if (ctl.shift)
        begin
            q_reg <= next_bits;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire
